// File: rtl/core/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// types, codes and constant tables of the character lcd nibble sequencer
// ----------------------------------------------------------------------------
package clns_pkg;

  localparam int MAX_DIGITS = 5;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_CMD       = 4'd1,
    OP_CHAR_HERE = 4'd2,
    OP_CHAR_AT   = 4'd3,
    OP_CLEAR     = 4'd4,
    OP_BLINK     = 4'd5,
    OP_NOBLINK   = 4'd6,
    OP_NUM_BLANK = 4'd7,
    OP_NUM_PAD   = 4'd8
  } opcode_e;

  localparam logic [7:0]  LINE1_BASE   = 8'h80;
  localparam logic [7:0]  LINE2_BASE   = 8'hC0;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  CMD_CLEAR    = 8'h01;
  localparam logic [7:0]  CMD_BLINK    = 8'h0D;
  localparam logic [7:0]  CMD_NOBLINK  = 8'h0C;
  localparam logic [12:0] WAIT_LOW     = 13'd50;
  localparam logic [12:0] WAIT_CLEAR   = 13'd2050;
  localparam logic [12:0] WAIT_BLINK   = 13'd150;
  localparam logic [12:0] WAIT_NOBLINK = 13'd100;
  localparam logic [15:0] WAIT_POWERUP = 16'd50000;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  col;
    logic [15:0] number;
    logic [2:0]  digit_count;
  } req_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        register_select;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } xfer_t;

  // powers of ten, index 0..5
  function automatic logic [16:0] pow10(input logic [2:0] idx);
    logic [16:0] p;
    case (idx)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

  // power-up sequence: four sync nibbles, then 0x28, 0x0C, 0x06, 0x01
  function automatic xfer_t init_xfer(input logic [3:0] idx);
    xfer_t x;
    x = '0;
    case (idx)
      4'd0:    begin x.nibble = 4'h3; x.wait_before_us = WAIT_POWERUP;
                     x.wait_after_us = 13'd5000; end
      4'd1:    begin x.nibble = 4'h3; x.wait_after_us = 13'd200; end
      4'd2:    begin x.nibble = 4'h3; x.wait_after_us = 13'd200; end
      4'd3:    begin x.nibble = 4'h2; x.wait_after_us = 13'd2000; end
      4'd4:    x.nibble = 4'h2;
      4'd5:    begin x.nibble = 4'h8; x.wait_after_us = WAIT_LOW; end
      4'd6:    x.nibble = 4'h0;
      4'd7:    begin x.nibble = 4'hC; x.wait_after_us = WAIT_LOW; end
      4'd8:    x.nibble = 4'h0;
      4'd9:    begin x.nibble = 4'h6; x.wait_after_us = WAIT_LOW; end
      4'd10:   x.nibble = 4'h0;
      4'd11:   begin x.nibble = 4'h1; x.wait_after_us = WAIT_CLEAR; end
      default: x = '0;
    endcase
    return x;
  endfunction

endpackage

// File: rtl/core/clns_req_if.sv
// ----------------------------------------------------------------------------
// clns_req_if
// request channel: valid/ready handshake with one request item
// ----------------------------------------------------------------------------
interface clns_req_if;
  logic          valid;
  logic          ready;
  clns_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/clns_xfer_if.sv
// ----------------------------------------------------------------------------
// clns_xfer_if
// transfer channel: valid/ready handshake with one bus transfer item
// ----------------------------------------------------------------------------
interface clns_xfer_if;
  logic           valid;
  logic           ready;
  clns_pkg::xfer_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/char_lcd_nibble_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// turns one lcd request into the run of 4-bit bus transfers that carries it
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | item
//  req_i    | in  | valid / ready | opcode, byte, row, col, number, digit count
//  xfer_o   | out | valid / ready | nibble, rs, wait before/after, last
//
//  a request carries 2 to 12 transfers, one transfer per cycle while xfer_o takes
//  them: init 12, address requests 4, numbers 2 + 2 * digits, unused opcodes are taken and dropped
//  the request register feeds the transfer register; the next request is
//  taken in the cycle the current one loads its last transfer
//  reset clears the busy flag and the output valid; payload is not reset
//  xfer_o.ready low with a transfer waiting freezes the sequencer;
//  req_i.ready then drops once busy
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core #(
  parameter int MaxDigits = clns_pkg::MAX_DIGITS
) (
  input logic    clk_i,
  input logic    rst_ni,
  clns_req_if.sink    req_i,
  clns_xfer_if.source xfer_o
);
  import clns_pkg::*;

  // request register
  logic        busy_q;
  opcode_e     op_q;
  logic [7:0]  bv_q;
  logic [7:0]  addr_q;
  logic [2:0]  cnt_q;
  logic        padded_q;
  logic [15:0] rem_q;
  logic        started_q;
  logic [3:0]  k_q;
  logic [3:0]  nxfer_q;

  // transfer register
  logic        out_valid_q;
  xfer_t       out_q;

  logic        emit, last_xfer, acc, op_ok, digit_step;
  logic [2:0]  byte_idx, pidx, cnt_c;
  logic        lo;
  logic [7:0]  byte_c, addr_c, digit_char;
  logic        rs_c;
  logic [12:0] wait_lo;
  logic [3:0]  digit, nxfer_c;
  logic [15:0] rem_next, sat_c;
  logic [16:0] limit_c;
  xfer_t       cur;

  clns_digit u_digit (
    .pidx_i     (pidx),
    .rem_i      (rem_q),
    .digit_o    (digit),
    .rem_next_o (rem_next)
  );

  // sequencing and handshakes
  always_comb begin
    byte_idx  = k_q[3:1];
    lo        = k_q[0];
    pidx      = cnt_q - byte_idx;
    last_xfer = (k_q == nxfer_q - 4'd1);
    emit      = busy_q && (!out_valid_q || xfer_o.ready);
    req_i.ready = !busy_q || (emit && last_xfer);
    acc       = req_i.valid && req_i.ready;
    op_ok     = (req_i.payload.opcode <= OP_NUM_PAD);
    digit_step = emit && lo && (byte_idx != 3'd0)
               && (op_q == OP_NUM_BLANK || op_q == OP_NUM_PAD);
  end

  // request decode: address command, clamped digit count, saturated value
  always_comb begin
    addr_c = ((req_i.payload.row == 2'd1) ? LINE1_BASE : LINE2_BASE)
           | 8'({2'b00, req_i.payload.col} - 8'd1);
    cnt_c = req_i.payload.digit_count;
    if (cnt_c == 3'd0) cnt_c = 3'd1;
    if (cnt_c > 3'(MaxDigits)) cnt_c = 3'(MaxDigits);
    limit_c = pow10(cnt_c);
    // too large for the field: all nines
    sat_c = ({1'b0, req_i.payload.number} >= limit_c) ? 16'(limit_c - 17'd1)
                                                      : req_i.payload.number;
    case (opcode_e'(req_i.payload.opcode))
      OP_INIT:                  nxfer_c = 4'd12;
      OP_CHAR_AT, OP_BLINK:     nxfer_c = 4'd4;
      OP_NUM_BLANK, OP_NUM_PAD: nxfer_c = 4'({cnt_c, 1'b0}) + 4'd2;
      default:                  nxfer_c = 4'd2;
    endcase
  end

  // blank mode shows spaces until the first nonzero digit; units always a digit
  assign digit_char = (padded_q || started_q || digit != 4'd0 || pidx == 3'd0)
                    ? 8'(CHAR_ZERO + {4'b0000, digit}) : CHAR_SPACE;

  // current transfer: byte byte_idx, high nibble first; init reads its table
  always_comb begin
    byte_c  = bv_q;
    rs_c    = 1'b0;
    wait_lo = WAIT_LOW;
    case (op_q)
      OP_CHAR_HERE: rs_c = 1'b1;
      OP_CHAR_AT: begin
        byte_c = (byte_idx == 3'd0) ? addr_q : bv_q;
        rs_c   = (byte_idx != 3'd0);
      end
      OP_CLEAR: begin
        byte_c  = CMD_CLEAR;
        wait_lo = WAIT_CLEAR;
      end
      OP_BLINK: begin
        byte_c = (byte_idx == 3'd0) ? addr_q : CMD_BLINK;
        if (byte_idx != 3'd0) wait_lo = WAIT_BLINK;
      end
      OP_NOBLINK: begin
        byte_c  = CMD_NOBLINK;
        wait_lo = WAIT_NOBLINK;
      end
      OP_NUM_BLANK, OP_NUM_PAD: begin
        byte_c = (byte_idx == 3'd0) ? addr_q : digit_char;
        rs_c   = (byte_idx != 3'd0);
      end
      default: ;
    endcase
    if (op_q == OP_INIT) begin
      cur = init_xfer(k_q);
    end else begin
      cur                 = '0;
      cur.nibble          = lo ? byte_c[3:0] : byte_c[7:4];
      cur.register_select = rs_c;
      cur.wait_after_us   = lo ? wait_lo : 13'd0;
    end
    cur.last = last_xfer;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        busy_q <= op_ok;
      end else if (emit && last_xfer) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (xfer_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and transfer payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= cur;
    end
    if (acc) begin
      op_q      <= opcode_e'(req_i.payload.opcode);
      bv_q      <= req_i.payload.byte_value;
      addr_q    <= addr_c;
      cnt_q     <= cnt_c;
      padded_q  <= (req_i.payload.opcode == OP_NUM_PAD);
      rem_q     <= sat_c;
      started_q <= 1'b0;
      k_q       <= 4'd0;
      nxfer_q   <= nxfer_c;
    end else begin
      if (emit) begin
        k_q <= k_q + 4'd1;
      end
      if (digit_step) begin
        rem_q <= rem_next;
        if (digit != 4'd0) started_q <= 1'b1;
      end
    end
  end

  assign xfer_o.valid   = out_valid_q;
  assign xfer_o.payload = out_q;

  // sequencer never runs past the request's transfer count
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q < nxfer_q))
    else $error("transfer index past end of request");

  // remainder always fits the digits still to come
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && byte_idx != 3'd0 && (op_q == OP_NUM_BLANK || op_q == OP_NUM_PAD))
    |-> ({1'b0, rem_q} < pow10(3'(pidx + 3'd1))))
    else $error("number remainder out of range");

  // an accepted request with a known opcode starts a run in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op_ok) |=> busy_q)
    else $error("accepted request did not start");

  // the last flag ends a run: no transfer is loaded without a request behind it
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_xfer && !acc) |=> !busy_q)
    else $error("request still busy after its last transfer");

endmodule

// File: rtl/core/clns_digit.sv
// ----------------------------------------------------------------------------
// clns_digit
// peels the leading decimal digit off a remainder for a given power of ten
// ----------------------------------------------------------------------------
module clns_digit (
  input  logic [2:0]  pidx_i,
  input  logic [15:0] rem_i,
  output logic [3:0]  digit_o,
  output logic [15:0] rem_next_o
);
  import clns_pkg::*;

  logic [16:0] thr [10];
  logic [16:0] sel;

  // parallel compares against 1p..9p, highest hit wins
  always_comb begin
    digit_o = 4'd0;
    sel     = '0;
    for (int d = 0; d < 10; d++) begin
      thr[d] = 17'(pow10(pidx_i) * 17'(d));
    end
    for (int d = 1; d < 10; d++) begin
      if ({1'b0, rem_i} >= thr[d]) begin
        digit_o = 4'(d);
        sel     = thr[d];
      end
    end
    rem_next_o = 16'({1'b0, rem_i} - sel);
  end

endmodule
